### hdl/dav_pkg.sv
// Shared constants, codes and types of the drag auto-scroll speed block.
package dav_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COORD_BITS_MAX = 32;

    localparam int TIME_W    = 32;
    localparam int LINES_W   = 12;
    localparam int LH_W      = 8;
    localparam int VEL_W     = 18;
    localparam int DIVISOR_W = 10;
    localparam int ZONE_W    = 3;
    localparam int SCALE_W   = 6;
    localparam int CFG_IDX_W = 2;

    // width of the quotient bit counter, sized for the longest division at the widest coordinates
    localparam int CNT_W = $clog2(COORD_BITS_MAX + 12 + 1);

    localparam int ZONE_LINES       = 4;
    localparam int EASE_MS_PER_LINE = 200;

    localparam int LH_RESET            = 16;
    localparam int SCREEN_TOP_RESET    = 0;
    localparam int SCREEN_BOTTOM_RESET = 768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_HEIGHT   = 2'd0,
        CFG_SCREEN_TOP    = 2'd1,
        CFG_SCREEN_BOTTOM = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_MOVE  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] nbits;
    } t_div_req;

endpackage

### hdl/dav_div.sv
// Shared restoring divider, one quotient bit per cycle over a chosen bit count.
module dav_div import dav_pkg::*; #(
    parameter int DIVIDEND_W = COORD_BITS_DEF + 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_req              i_req,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_q;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;
    logic [CNT_W-1:0]      w_align;

    assign w_trial = {r_rem, r_q[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    // park the used dividend bits at the top so they shift out MSB first
    assign w_align = CNT_W'(DIVIDEND_W) - i_req.nbits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.go) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_q   <= i_dividend << w_align;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_q   <= {r_q[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### hdl/dav_core.sv
// Sequencer and datapath: zone setup, arming, entry times and eased speed.
module dav_core import dav_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_pointer_y,
    input  logic [TIME_W-1:0]            i_time_ms,
    input  logic signed [COORD_BITS-1:0] i_frame_top,
    input  logic signed [COORD_BITS-1:0] i_frame_bottom,
    input  logic [LINES_W-1:0]           i_frame_lines,
    input  logic [LH_W-1:0]              i_line_height,
    input  logic signed [COORD_BITS-1:0] i_screen_top,
    input  logic signed [COORD_BITS-1:0] i_screen_bottom,
    input  logic                         i_res_take,
    output logic                         o_idle,
    output logic                         o_res_valid,
    output logic [VEL_W-1:0]             o_velocity
);

    localparam int CW = COORD_BITS;
    localparam int EW = CW + 1;   // zone edges and coordinate differences
    localparam int SW = CW + 2;   // sweep below a zone edge
    localparam int MW = CW + 3;   // shared multiplier, signed operand
    localparam int PW = CW + 14;  // shared multiplier product
    localparam int DW = CW + 12;  // dividend of the easing division
    localparam int LW = CW + 10;  // line boundaries in pixels
    localparam int VW = (CW + 4 > VEL_W) ? CW + 4 : VEL_W;

    localparam logic [EW-1:0] SAT_P = {2'b00, {(CW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_N = {2'b01, {(CW-1){1'b0}}};

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_BEGIN  = 17'h00002,
        S_WSTART = 17'h00004,
        S_CHK    = 17'h00008,
        S_WABOVE = 17'h00010,
        S_WBELOW = 17'h00020,
        S_CAP    = 17'h00040,
        S_WSCALE = 17'h00080,
        S_ZONE   = 17'h00100,
        S_MUL    = 17'h00200,
        S_MOVE   = 17'h00400,
        S_WSWEEP = 17'h00800,
        S_EMUL   = 17'h01000,
        S_EDIV   = 17'h02000,
        S_WEASE  = 17'h04000,
        S_VEL    = 17'h08000,
        S_DONE   = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // captured item
    logic signed [CW-1:0]  r_y;
    logic [TIME_W-1:0]     r_now;
    logic signed [CW-1:0]  r_ftop;
    logic signed [CW-1:0]  r_fbot;
    logic [LINES_W-1:0]    r_flines;

    // drag state
    logic signed [CW-1:0]  r_start_line;
    logic signed [CW-1:0]  r_seen_top;
    logic signed [CW-1:0]  r_seen_bot;
    logic signed [EW-1:0]  r_top_edge;
    logic signed [EW-1:0]  r_bot_edge;
    logic [DIVISOR_W-1:0]  r_top_ease;
    logic [DIVISOR_W-1:0]  r_bot_ease;
    logic                  r_moved_up;
    logic                  r_moved_down;
    logic                  r_in_top;
    logic                  r_in_bot;
    logic [TIME_W-1:0]     r_top_entry;
    logic [TIME_W-1:0]     r_bot_entry;

    // working registers
    logic                  r_neg;
    logic [ZONE_W-1:0]     r_ztop;
    logic [ZONE_W-1:0]     r_zbot;
    logic [2:0]            r_cap3;
    logic signed [PW-1:0]  r_prod;
    logic                  r_up;
    logic                  r_ease_on;
    logic [DIVISOR_W-1:0]  r_elap10;
    logic [DIVISOR_W-1:0]  r_period;
    logic [SW-1:0]         r_eased;
    logic [VEL_W-1:0]      r_vel;

    // divider hookup
    t_div_req              w_div_req;
    logic [DW-1:0]         w_div_dividend;
    logic [DIVISOR_W-1:0]  w_div_divisor;
    logic                  w_div_done;
    logic [DW-1:0]         w_quot;

    logic [LH_W-1:0]       w_lh;
    logic signed [EW-1:0]  w_y_e;
    logic signed [EW-1:0]  w_ftop_e;
    logic signed [EW-1:0]  w_fbot_e;
    logic signed [EW-1:0]  w_begin_diff;
    logic [EW-1:0]         w_begin_mag;
    logic signed [EW-1:0]  w_above;
    logic signed [EW-1:0]  w_below;
    logic [EW-1:0]         w_q_line;
    logic signed [CW-1:0]  w_sat_line;
    logic [ZONE_W-1:0]     w_qzone;
    logic                  w_frame_new;
    logic [ZONE_W:0]       w_sum;
    logic [LINES_W-2:0]    w_cap;
    logic                  w_over;
    logic [SCALE_W-1:0]    w_scale_num;
    logic [10:0]           w_tz_px;
    logic [10:0]           w_bz_px;
    logic signed [MW-1:0]  w_mul_a;
    logic [DIVISOR_W-1:0]  w_mul_b;
    logic signed [PW-1:0]  w_mul_p;
    logic signed [LW-1:0]  w_y_l;
    logic signed [LW-1:0]  w_line0;
    logic signed [LW-1:0]  w_line1;
    logic                  w_mu;
    logic                  w_md;
    logic                  w_it;
    logic                  w_ib;
    logic [TIME_W-1:0]     w_tent;
    logic [TIME_W-1:0]     w_bent;
    logic [TIME_W-1:0]     w_tel;
    logic [TIME_W-1:0]     w_bel;
    logic [SW-1:0]         w_tsweep;
    logic [SW-1:0]         w_bsweep;
    logic signed [VW-1:0]  w_eased_v;
    logic signed [VW-1:0]  w_vel;

    dav_div #(
        .DIVIDEND_W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // a line height of zero counts as one
    assign w_lh = (i_line_height == '0) ? LH_W'(1) : i_line_height;

    assign w_y_e    = $signed({r_y[CW-1], r_y});
    assign w_ftop_e = $signed({r_ftop[CW-1], r_ftop});
    assign w_fbot_e = $signed({r_fbot[CW-1], r_fbot});

    assign w_begin_diff = w_y_e - w_ftop_e;
    assign w_begin_mag  = w_begin_diff[EW-1] ? -w_begin_diff : w_begin_diff;
    assign w_above = w_ftop_e - $signed({i_screen_top[CW-1], i_screen_top});
    assign w_below = $signed({i_screen_bottom[CW-1], i_screen_bottom}) - w_fbot_e;

    // start line: magnitude quotient, sign put back, then saturated
    assign w_q_line = w_quot[EW-1:0];
    always_comb begin
        if (!r_neg)
            w_sat_line = (w_q_line > SAT_P) ? $signed(SAT_P[CW-1:0])
                                            : $signed(w_q_line[CW-1:0]);
        else
            w_sat_line = (w_q_line > SAT_N) ? $signed(SAT_N[CW-1:0])
                                            : $signed(-w_q_line[CW-1:0]);
    end

    assign w_qzone = (w_quot < DW'(ZONE_LINES)) ?
                     ZONE_W'(ZONE_LINES) - w_quot[ZONE_W-1:0] : '0;

    assign w_frame_new = (r_seen_top != r_ftop) || (r_seen_bot != r_fbot);

    // zone cap is half the frame lines
    assign w_sum       = {1'b0, r_ztop} + {1'b0, r_zbot};
    assign w_cap       = r_flines[LINES_W-1:1];
    assign w_over      = ((LINES_W-1)'(w_sum) > w_cap);
    assign w_scale_num = ({3'b000, r_zbot} * {3'b000, w_cap[2:0]})
                       + SCALE_W'(w_sum >> 1);

    assign w_tz_px = 11'(r_ztop) * 11'(w_lh);
    assign w_bz_px = 11'(r_zbot) * 11'(w_lh);

    // shared multiplier: line height by start line, or sweep by elapsed time
    assign w_mul_a = (r_state == S_EMUL) ? $signed({1'b0, r_eased})
                                         : $signed({{3{r_start_line[CW-1]}}, r_start_line});
    assign w_mul_b = (r_state == S_EMUL) ? r_elap10 : {{(DIVISOR_W-LH_W){1'b0}}, w_lh};
    assign w_mul_p = w_mul_a * $signed({1'b0, w_mul_b});

    assign w_y_l   = $signed({{(LW-CW){r_y[CW-1]}}, r_y});
    assign w_line0 = $signed({{(LW-CW){r_seen_top[CW-1]}}, r_seen_top})
                   + $signed(r_prod[LW-1:0]);
    assign w_line1 = w_line0 + $signed({{(LW-LH_W){1'b0}}, w_lh});

    assign w_mu = r_moved_up   || (w_y_l < w_line0);
    assign w_md = r_moved_down || (w_y_l >= w_line1);
    assign w_it = w_mu && (w_y_e <= r_top_edge);
    assign w_ib = w_md && (w_y_e >= r_bot_edge);

    assign w_tent = (!r_in_top && w_it) ? r_now : r_top_entry;
    assign w_bent = (!r_in_bot && w_ib) ? r_now : r_bot_entry;
    assign w_tel  = r_now - w_tent;
    assign w_bel  = r_now - w_bent;

    assign w_tsweep = {r_top_edge[EW-1], r_top_edge} - {w_y_e[EW-1], w_y_e};
    assign w_bsweep = {w_y_e[EW-1], w_y_e} - {r_bot_edge[EW-1], r_bot_edge};

    // -1 - e is ~e
    assign w_eased_v = $signed({{(VW-SW){1'b0}}, r_eased});
    assign w_vel     = r_up ? ~w_eased_v : w_eased_v + $signed(VW'(1));

    always_comb begin
        n_state        = r_state;
        w_div_req.go    = 1'b0;
        w_div_req.nbits = '0;
        w_div_dividend = '0;
        w_div_divisor  = {{(DIVISOR_W-LH_W){1'b0}}, w_lh};
        unique case (r_state)
            S_IDLE: begin
                if (i_start)
                    n_state = (i_opcode == OP_BEGIN) ? S_BEGIN : S_CHK;
            end
            S_BEGIN: begin
                w_div_req.go    = 1'b1;
                w_div_req.nbits = CNT_W'(EW);
                w_div_dividend  = {{(DW-EW){1'b0}}, w_begin_mag};
                n_state         = S_WSTART;
            end
            S_WSTART: begin
                if (w_div_done)
                    n_state = S_CHK;
            end
            S_CHK: begin
                if (w_frame_new) begin
                    w_div_req.go    = 1'b1;
                    w_div_req.nbits = CNT_W'(EW);
                    w_div_dividend  = w_above[EW-1] ? '0 : {{(DW-EW){1'b0}}, w_above};
                    n_state         = S_WABOVE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_WABOVE: begin
                if (w_div_done) begin
                    w_div_req.go    = 1'b1;
                    w_div_req.nbits = CNT_W'(EW);
                    w_div_dividend  = w_below[EW-1] ? '0 : {{(DW-EW){1'b0}}, w_below};
                    n_state         = S_WBELOW;
                end
            end
            S_WBELOW: begin
                if (w_div_done)
                    n_state = S_CAP;
            end
            S_CAP: begin
                if (w_over) begin
                    w_div_req.go    = 1'b1;
                    w_div_req.nbits = CNT_W'(SCALE_W);
                    w_div_dividend  = {{(DW-SCALE_W){1'b0}}, w_scale_num};
                    w_div_divisor   = {{(DIVISOR_W-ZONE_W-1){1'b0}}, w_sum};
                    n_state         = S_WSCALE;
                end else begin
                    n_state = S_ZONE;
                end
            end
            S_WSCALE: begin
                if (w_div_done)
                    n_state = S_ZONE;
            end
            S_ZONE: n_state = S_MUL;
            S_MUL:  n_state = S_MOVE;
            S_MOVE: begin
                if (w_it) begin
                    w_div_req.go    = 1'b1;
                    w_div_req.nbits = CNT_W'(SW);
                    w_div_dividend  = {{(DW-SW){1'b0}}, w_tsweep};
                    n_state         = S_WSWEEP;
                end else if (w_ib) begin
                    w_div_req.go    = 1'b1;
                    w_div_req.nbits = CNT_W'(SW);
                    w_div_dividend  = {{(DW-SW){1'b0}}, w_bsweep};
                    n_state         = S_WSWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WSWEEP: begin
                if (w_div_done)
                    n_state = r_ease_on ? S_EMUL : S_VEL;
            end
            S_EMUL: n_state = S_EDIV;
            S_EDIV: begin
                w_div_req.go    = 1'b1;
                w_div_req.nbits = CNT_W'(DW);
                w_div_dividend  = r_prod[DW-1:0];
                w_div_divisor   = r_period;
                n_state         = S_WEASE;
            end
            S_WEASE: begin
                if (w_div_done)
                    n_state = S_VEL;
            end
            S_VEL: n_state = S_DONE;
            S_DONE: begin
                if (i_res_take)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_line <= '0;
            r_seen_top   <= '0;
            r_seen_bot   <= '0;
            r_top_edge   <= '0;
            r_bot_edge   <= '0;
            r_top_ease   <= '0;
            r_bot_ease   <= '0;
            r_moved_up   <= 1'b0;
            r_moved_down <= 1'b0;
            r_in_top     <= 1'b0;
            r_in_bot     <= 1'b0;
            r_top_entry  <= '0;
            r_bot_entry  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    // begin event wipes the drag, stored frame bounds included
                    if (i_start && (i_opcode == OP_BEGIN)) begin
                        r_start_line <= '0;
                        r_seen_top   <= '0;
                        r_seen_bot   <= '0;
                        r_top_edge   <= '0;
                        r_bot_edge   <= '0;
                        r_top_ease   <= '0;
                        r_bot_ease   <= '0;
                        r_moved_up   <= 1'b0;
                        r_moved_down <= 1'b0;
                        r_in_top     <= 1'b0;
                        r_in_bot     <= 1'b0;
                        r_top_entry  <= '0;
                        r_bot_entry  <= '0;
                    end
                end
                S_WSTART: begin
                    if (w_div_done)
                        r_start_line <= w_sat_line;
                end
                S_CHK: begin
                    if (w_frame_new) begin
                        r_seen_top <= r_ftop;
                        r_seen_bot <= r_fbot;
                    end
                end
                S_ZONE: begin
                    r_top_edge <= w_ftop_e - $signed(EW'(1))
                                + $signed({{(EW-11){1'b0}}, w_tz_px});
                    r_bot_edge <= w_fbot_e - $signed({{(EW-11){1'b0}}, w_bz_px});
                    r_top_ease <= DIVISOR_W'(r_ztop) * DIVISOR_W'(EASE_MS_PER_LINE);
                    r_bot_ease <= DIVISOR_W'(r_zbot) * DIVISOR_W'(EASE_MS_PER_LINE);
                end
                S_MOVE: begin
                    r_moved_up   <= w_mu;
                    r_moved_down <= w_md;
                    r_in_top     <= w_it;
                    r_in_bot     <= w_ib;
                    r_top_entry  <= w_tent;
                    r_bot_entry  <= w_bent;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_y      <= i_pointer_y;
            r_now    <= i_time_ms;
            r_ftop   <= i_frame_top;
            r_fbot   <= i_frame_bottom;
            r_flines <= i_frame_lines;
        end
        unique case (r_state)
            S_BEGIN: r_neg <= w_begin_diff[EW-1];
            S_WABOVE: begin
                if (w_div_done)
                    r_ztop <= w_qzone;
            end
            S_WBELOW: begin
                if (w_div_done)
                    r_zbot <= w_qzone;
            end
            S_CAP: r_cap3 <= w_cap[2:0];
            S_WSCALE: begin
                // bottom zone rescaled, top takes the rest of the cap
                if (w_div_done) begin
                    r_zbot <= w_quot[ZONE_W-1:0];
                    r_ztop <= r_cap3 - w_quot[ZONE_W-1:0];
                end
            end
            S_MUL:  r_prod <= w_mul_p;
            S_EMUL: r_prod <= w_mul_p;
            S_MOVE: begin
                if (w_it) begin
                    r_up      <= 1'b1;
                    r_period  <= r_top_ease;
                    r_ease_on <= (w_tel < {{(TIME_W-DIVISOR_W){1'b0}}, r_top_ease});
                    r_elap10  <= w_tel[DIVISOR_W-1:0];
                end else if (w_ib) begin
                    r_up      <= 1'b0;
                    r_period  <= r_bot_ease;
                    r_ease_on <= (w_bel < {{(TIME_W-DIVISOR_W){1'b0}}, r_bot_ease});
                    r_elap10  <= w_bel[DIVISOR_W-1:0];
                end else begin
                    r_vel <= '0;
                end
            end
            S_WSWEEP: begin
                if (w_div_done)
                    r_eased <= w_quot[SW-1:0];
            end
            S_WEASE: begin
                if (w_div_done)
                    r_eased <= w_quot[SW-1:0];
            end
            S_VEL: r_vel <= w_vel[VEL_W-1:0];
            default: ;
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_velocity  = r_vel;

endmodule

### hdl/drag_autoscroll_velocity_top.sv
// Drag auto-scroll speed: configuration registers, core and output register.
//
//  channel  | valid / ready            | payload
//  ---------+--------------------------+--------------------------------------------
//  item in  | i_valid / o_ready        | i_opcode i_pointer_y i_time_ms i_frame_top
//           |                          | i_frame_bottom i_frame_lines
//  result   | o_valid / i_ready        | o_velocity
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index i_cfg_data
//
// An item uses the one shared serial divider for each of its divisions, each over
// its own count of quotient bits: from none (no zone) to six (begin with new frame
// bounds, rescaled zones and easing).
// Reset is synchronous, active low; it restores the register defaults and
// clears all drag state. A held result stalls the core until it is taken;
// o_ready stays low from acceptance until the result enters the output register.
module drag_autoscroll_velocity_top import dav_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_pointer_y,
    input  logic [TIME_W-1:0]            i_time_ms,
    input  logic signed [COORD_BITS-1:0] i_frame_top,
    input  logic signed [COORD_BITS-1:0] i_frame_bottom,
    input  logic [LINES_W-1:0]           i_frame_lines,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [VEL_W-1:0]      o_velocity,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data
);

    logic [LH_W-1:0]              r_line_height;
    logic signed [COORD_BITS-1:0] r_screen_top;
    logic signed [COORD_BITS-1:0] r_screen_bottom;
    logic                         r_out_valid;
    logic [VEL_W-1:0]             r_velocity;

    logic                         w_core_idle;
    logic                         w_res_valid;
    logic [VEL_W-1:0]             w_res_vel;
    logic                         w_out_load;
    logic                         w_accept;

    assign w_accept   = i_valid && w_core_idle;
    assign w_out_load = w_res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_height   <= LH_W'(LH_RESET);
            r_screen_top    <= COORD_BITS'(SCREEN_TOP_RESET);
            r_screen_bottom <= COORD_BITS'(SCREEN_BOTTOM_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINE_HEIGHT:   r_line_height   <= i_cfg_data[LH_W-1:0];
                CFG_SCREEN_TOP:    r_screen_top    <= $signed(i_cfg_data);
                CFG_SCREEN_BOTTOM: r_screen_bottom <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    dav_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_accept),
        .i_opcode        (i_opcode),
        .i_pointer_y     (i_pointer_y),
        .i_time_ms       (i_time_ms),
        .i_frame_top     (i_frame_top),
        .i_frame_bottom  (i_frame_bottom),
        .i_frame_lines   (i_frame_lines),
        .i_line_height   (r_line_height),
        .i_screen_top    (r_screen_top),
        .i_screen_bottom (r_screen_bottom),
        .i_res_take      (w_out_load),
        .o_idle          (w_core_idle),
        .o_res_valid     (w_res_valid),
        .o_velocity      (w_res_vel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_out_load)
            r_out_valid <= 1'b1;
        else if (i_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load)
            r_velocity <= w_res_vel;
    end

    assign o_ready     = w_core_idle;
    assign o_valid     = r_out_valid;
    assign o_velocity  = $signed(r_velocity);
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block still ready after taking an item");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_out_load) |=> (w_res_valid && $stable(w_res_vel)))
        else $error("core result dropped or changed before hand-off");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_valid && (r_velocity == $past(w_res_vel))))
        else $error("loaded result not presented");
`endif

endmodule
